### rtl/core/pulse_period_to_rpm_core_defines.svh
// ----------------------------------------------------------------------------
// pulse_period_to_rpm_core_defines
// Assertion macros used by the core's sequencer (pprpm_ctrl).
// ----------------------------------------------------------------------------
`ifndef PULSE_PERIOD_TO_RPM_CORE_DEFINES_SVH
`define PULSE_PERIOD_TO_RPM_CORE_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge outside reset
`define PPR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define PPR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/pprpm_pkg.sv
// ----------------------------------------------------------------------------
// pprpm_pkg
// Widths, reset values, register indexes and control types of the core.
// ----------------------------------------------------------------------------
package pprpm_pkg;

    localparam int TIMER_BITS_DEF = 16;
    localparam int TIMER_IN_W     = 16;
    localparam int MIN_W          = 16;
    localparam int SCALE_W        = 32;
    localparam int SPEED_W        = 16;
    localparam int INTERVAL_OUT_W = 17;
    localparam int COUNT_W        = 32;
    localparam int CFG_DATA_W     = 32;
    localparam int CFG_INDEX_W    = 1;

    localparam logic [MIN_W-1:0]   MIN_INTERVAL_RST = MIN_W'(11333 / 2);
    localparam logic [SCALE_W-1:0] SPEED_SCALE_RST  = SCALE_W'(1000000 * 60 / 2);

    localparam logic [CFG_INDEX_W-1:0] REG_MIN_INTERVAL = 1'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_SPEED_SCALE  = 1'd1;

    // controller to datapath
    typedef struct packed {
        logic capture;  // latch the stamp of an accepted request
        logic check;    // form the interval, test it, load the divider
        logic step;     // one restoring divide step
        logic commit;   // update state; output register takes the result
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic glitch;   // interval below min_interval, valid during check
    } sts_t;

endpackage

### rtl/core/pprpm_if.sv
// ----------------------------------------------------------------------------
// pprpm_if
// Valid/ready channels: sensor edge requests in, speed results out.
// ----------------------------------------------------------------------------
interface pprpm_in_if;
    import pprpm_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [TIMER_IN_W-1:0] timer_count;

    modport source (output valid, output timer_count, input ready);
    modport sink   (input valid, input timer_count, output ready);
endinterface

interface pprpm_out_if;
    import pprpm_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      accepted;
    logic [INTERVAL_OUT_W-1:0] interval_ticks;
    logic [SPEED_W-1:0]        speed_rpm;
    logic [COUNT_W-1:0]        pulse_total;
    logic [COUNT_W-1:0]        glitch_total;

    modport source (output valid, output accepted, output interval_ticks,
                    output speed_rpm, output pulse_total, output glitch_total,
                    input ready);
    modport sink   (input valid, input accepted, input interval_ticks,
                    input speed_rpm, input pulse_total, input glitch_total,
                    output ready);
endinterface

### rtl/core/pulse_period_to_rpm_core.sv
// ----------------------------------------------------------------------------
// pulse_period_to_rpm_core
// Tachometer: sensor edge timer stamps in, interval and speed out.
// ----------------------------------------------------------------------------
// Usage:
//   sensor : one request per falling edge, carrying the 16-bit timer stamp.
//   result : one item per request: accepted flag, last interval, speed,
//            accepted and rejected edge counts.
//   cfg_*  : min_interval (index 0) and speed_scale (index 1); write only
//            while no request is in flight.
// Sequence: a good edge goes from acceptance through one capture, one interval
//   test, 32 steps of the serial restoring divider (one quotient bit per
//   cycle) and one commit; the input slot opens again after the commit.
//   Result valid is registered from the commit. A glitch skips the divider and
//   goes from the interval test straight to commit.
// The result sits in an output register; the next request is accepted and
//   worked while it waits. If the receiver stalls, the finished second result
//   holds at commit until the register is taken, and the input stays closed.
// Reset: clears speed state and counters, loads the config defaults; the
//   block takes a request at the first edge after reset is released.
// ----------------------------------------------------------------------------
module pulse_period_to_rpm_core #(
    parameter int TIMER_BITS = pprpm_pkg::TIMER_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [pprpm_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [pprpm_pkg::CFG_DATA_W-1:0]  cfg_data,
    pprpm_in_if.sink                          sensor,
    pprpm_out_if.source                       result
);
    import pprpm_pkg::*;

    cmd_t cmd;
    sts_t sts;

    pprpm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sensor.valid),
        .in_ready  (sensor.ready),
        .out_valid (result.valid),
        .out_ready (result.ready),
        .cmd       (cmd),
        .sts       (sts)
    );

    pprpm_datapath #(
        .TIMER_BITS (TIMER_BITS)
    ) u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .timer_count    (sensor.timer_count),
        .cmd            (cmd),
        .sts            (sts),
        .accepted       (result.accepted),
        .interval_ticks (result.interval_ticks),
        .speed_rpm      (result.speed_rpm),
        .pulse_total    (result.pulse_total),
        .glitch_total   (result.glitch_total)
    );

endmodule

### rtl/core/pprpm_datapath.sv
// ----------------------------------------------------------------------------
// pprpm_datapath
// Config registers, interval/glitch test, serial divider and speed state.
// ----------------------------------------------------------------------------
module pprpm_datapath #(
    parameter int TIMER_BITS = pprpm_pkg::TIMER_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [pprpm_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [pprpm_pkg::CFG_DATA_W-1:0]    cfg_data,
    input  logic [pprpm_pkg::TIMER_IN_W-1:0]    timer_count,
    input  pprpm_pkg::cmd_t                     cmd,
    output pprpm_pkg::sts_t                     sts,
    output logic                                accepted,
    output logic [pprpm_pkg::INTERVAL_OUT_W-1:0] interval_ticks,
    output logic [pprpm_pkg::SPEED_W-1:0]       speed_rpm,
    output logic [pprpm_pkg::COUNT_W-1:0]       pulse_total,
    output logic [pprpm_pkg::COUNT_W-1:0]       glitch_total
);
    import pprpm_pkg::*;

    localparam int TB    = TIMER_BITS;
    localparam int SB    = (TB < TIMER_IN_W) ? TB : TIMER_IN_W;  // stored stamp bits
    localparam int IW    = TB + 1;                               // full wrap needs one more
    localparam int CMP_W = (IW > MIN_W) ? IW : MIN_W;

    logic [MIN_W-1:0]   min_reg;
    logic [SCALE_W-1:0] scale_reg;

    logic [SB-1:0]      stamp_reg;
    logic [SB-1:0]      last_stamp_reg;
    logic [IW-1:0]      span_reg;
    logic               ok_reg;
    logic [IW-1:0]      last_interval_reg;
    logic [SPEED_W-1:0] speed_reg;
    logic [COUNT_W-1:0] pulse_reg;
    logic [COUNT_W-1:0] glitch_reg;
    logic               out_ok_reg;

    logic [IW-1:0]      rem_reg;
    logic [SCALE_W-1:0] dividend_reg;
    logic [SPEED_W-1:0] quot_reg;

    logic [TB-1:0]      diff;
    logic [IW-1:0]      span;
    logic               glitch;
    logic [IW:0]        rem_sh;
    logic               fits;
    logic [IW:0]        rem_sub;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_reg   <= MIN_INTERVAL_RST;
            scale_reg <= SPEED_SCALE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_INTERVAL: min_reg   <= cfg_data[MIN_W-1:0];
                REG_SPEED_SCALE:  scale_reg <= cfg_data[SCALE_W-1:0];
            endcase
        end
    end

    // elapsed ticks modulo the timer span; equal stamps mean a full wrap
    always_comb
    begin
        diff = TB'(TB'(stamp_reg) - TB'(last_stamp_reg));
        if (diff == '0)
            span = {1'b1, {TB{1'b0}}};
        else
            span = IW'(diff);
        glitch = CMP_W'(span) < CMP_W'(min_reg);
    end

    assign sts.glitch = glitch;

    // restoring divide, one quotient bit per step
    always_comb
    begin
        rem_sh  = {rem_reg, dividend_reg[SCALE_W-1]};
        fits    = rem_sh >= {1'b0, span_reg};
        rem_sub = rem_sh - {1'b0, span_reg};
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
            stamp_reg <= SB'(timer_count);
        if (cmd.check)
        begin
            span_reg     <= span;
            ok_reg       <= !glitch;
            rem_reg      <= '0;
            dividend_reg <= scale_reg;
            quot_reg     <= '0;
        end
        else if (cmd.step)
        begin
            rem_reg      <= fits ? rem_sub[IW-1:0] : rem_sh[IW-1:0];
            dividend_reg <= {dividend_reg[SCALE_W-2:0], 1'b0};
            quot_reg     <= {quot_reg[SPEED_W-2:0], fits};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_stamp_reg    <= '0;
            last_interval_reg <= '0;
            speed_reg         <= '0;
            pulse_reg         <= '0;
            glitch_reg        <= '0;
            out_ok_reg        <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_ok_reg <= ok_reg;
            if (ok_reg)
            begin
                last_stamp_reg    <= stamp_reg;
                last_interval_reg <= span_reg;
                speed_reg         <= quot_reg;
                pulse_reg         <= pulse_reg + 1'b1;
            end
            else
            begin
                glitch_reg <= glitch_reg + 1'b1;
            end
        end
    end

    // state only moves on commit, which waits for the output to be free
    assign accepted       = out_ok_reg;
    assign interval_ticks = INTERVAL_OUT_W'(last_interval_reg);
    assign speed_rpm      = speed_reg;
    assign pulse_total    = pulse_reg;
    assign glitch_total   = glitch_reg;

endmodule

### rtl/core/pprpm_ctrl.sv
// ----------------------------------------------------------------------------
// pprpm_ctrl
// Sequencer: accept, test, divide (skipped for a glitch), commit into the output register.
// ----------------------------------------------------------------------------
`include "pulse_period_to_rpm_core_defines.svh"

module pprpm_ctrl (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    output logic            in_ready,
    output logic            out_valid,
    input  logic            out_ready,
    output pprpm_pkg::cmd_t cmd,
    input  pprpm_pkg::sts_t sts
);
    import pprpm_pkg::*;

    localparam int DIV_STEPS = SCALE_W;
    localparam int CNT_W     = $clog2(DIV_STEPS);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_CHECK = 2'd1;
    localparam logic [1:0] ST_DIV   = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_free;

    assign out_free = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        in_ready       = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                cmd.check = 1'b1;
                cnt_next  = '0;
                state_next = sts.glitch ? ST_DONE : ST_DIV;
            end
            ST_DIV:
            begin
                cmd.step = 1'b1;
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == CNT_LAST)
                    state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    `PPR_ASSERT_NOW(a_commit_free, cmd.commit, !out_valid_reg || out_ready, "commit over a pending result")
    `PPR_ASSERT_NEXT(a_div_len, state_reg == ST_DIV && cnt_reg == CNT_LAST, state_reg == ST_DONE, "divide did not end after last step")
    `PPR_ASSERT_NEXT(a_check_branch, state_reg == ST_CHECK && !sts.glitch, state_reg == ST_DIV && cnt_reg == '0, "good interval skipped the divide")
    `PPR_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid_reg, "committed result not presented")

endmodule

### verif/tb_pulse_period_to_rpm_core.sv
// ----------------------------------------------------------------------------
// tb_pulse_period_to_rpm_core
// Self-checking bench for the tachometer core: timer stamps in, speed out.
// ----------------------------------------------------------------------------
// Sensor edge requests are queued by the stimulus process and offered in
// random bursts. Each accepted request runs through an in-bench predictor
// that keeps its own copy of the stamp, interval, speed, counters and
// registers. The monitor stalls the result side on changing patterns,
// including one long hold-off, and checks every result field by field
// against the oldest prediction. Registers change only while nothing is in
// flight, across default, extreme and random settings.
// ----------------------------------------------------------------------------
module tb_pulse_period_to_rpm_core;
    import pprpm_pkg::*;

    typedef struct packed {
        logic                      accepted;
        logic [INTERVAL_OUT_W-1:0] interval_ticks;
        logic [SPEED_W-1:0]        speed_rpm;
        logic [COUNT_W-1:0]        pulse_total;
        logic [COUNT_W-1:0]        glitch_total;
    } tach_result_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_we;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    pprpm_in_if  sensor_ch ();
    pprpm_out_if result_ch ();

    pulse_period_to_rpm_core DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sensor    (sensor_ch),
        .result    (result_ch)
    );

    // predictor state and register copy
    logic [TIMER_IN_W-1:0]     prev_stamp     = '0;
    logic [INTERVAL_OUT_W-1:0] held_interval  = '0;
    logic [SPEED_W-1:0]        held_speed     = '0;
    logic [COUNT_W-1:0]        pulses_seen    = '0;
    logic [COUNT_W-1:0]        glitches_seen  = '0;
    logic [MIN_W-1:0]          cur_min_interval = MIN_INTERVAL_RST;
    logic [SCALE_W-1:0]        cur_scale        = SPEED_SCALE_RST;

    // generator's view of the last accepted stamp, used to aim intervals
    logic [TIMER_IN_W-1:0]     gen_last = '0;

    logic [TIMER_IN_W-1:0] stamp_q[$];
    tach_result_t          speed_expect_q[$];

    int fail_count      = 0;
    int results_checked = 0;
    int settings_done   = 0;

    // driver pacing
    logic send_fire;
    int   burst_left = 1;
    int   gap_left   = 0;

    // monitor pacing
    int hold_request   = 0;
    int hold_served    = 0;
    int long_hold_left = 0;
    int stall_mode     = 0;
    int mode_left      = 0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial begin
        #2000000;
        $display("pulse_period_to_rpm_core verification failed");
        $finish;
    end

    // interval since the last accepted stamp, equal stamps meaning a full wrap
    function automatic logic [INTERVAL_OUT_W-1:0] wrap_interval(
        input logic [TIMER_IN_W-1:0] now_stamp,
        input logic [TIMER_IN_W-1:0] old_stamp
    );
        logic [TIMER_IN_W-1:0] diff;
        diff = now_stamp - old_stamp;
        return (diff == '0) ? 17'h10000 : {1'b0, diff};
    endfunction

    task automatic predict_edge(input logic [TIMER_IN_W-1:0] stamp);
        logic [INTERVAL_OUT_W-1:0] span;
        logic [SCALE_W-1:0]        quot;
        tach_result_t              r;
        span = wrap_interval(stamp, prev_stamp);
        r.accepted = 1'b0;
        if (span < {1'b0, cur_min_interval}) begin
            glitches_seen = glitches_seen + 1;
        end
        else begin
            r.accepted    = 1'b1;
            prev_stamp    = stamp;
            held_interval = span;
            quot          = cur_scale / {15'd0, span};
            held_speed    = quot[SPEED_W-1:0];
            pulses_seen   = pulses_seen + 1;
        end
        r.interval_ticks = held_interval;
        r.speed_rpm      = held_speed;
        r.pulse_total    = pulses_seen;
        r.glitch_total   = glitches_seen;
        speed_expect_q.push_back(r);
    endtask

    // ---------------- driver ----------------
    always @(posedge clk) begin
        if (rst_n) begin
            send_fire = sensor_ch.valid && sensor_ch.ready;
            if (send_fire) begin
                predict_edge(sensor_ch.timer_count);
                void'(stamp_q.pop_front());
            end
            if (sensor_ch.valid && !send_fire) begin
                // request still pending: hold it
            end
            else if (gap_left > 0) begin
                gap_left--;
                sensor_ch.valid <= 1'b0;
            end
            else if (stamp_q.size() > 0) begin
                sensor_ch.valid       <= 1'b1;
                sensor_ch.timer_count <= stamp_q[0];
                if (burst_left > 1) begin
                    burst_left--;
                end
                else begin
                    burst_left = $urandom_range(1, 24);
                    gap_left   = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 45) : 0;
                end
            end
            else begin
                sensor_ch.valid <= 1'b0;
            end
        end
    end

    // ---------------- monitor ----------------
    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge clk) begin
        tach_result_t want;
        if (rst_n) begin
            if (result_ch.valid && result_ch.ready) begin
                if (speed_expect_q.size() == 0) begin
                    $display("%0t: result with nothing expected, got accepted %0d speed %0d",
                             $time, result_ch.accepted, result_ch.speed_rpm);
                    fail_count++;
                end
                else begin
                    want = speed_expect_q.pop_front();
                    check_field("accepted", 32'(want.accepted), 32'(result_ch.accepted));
                    check_field("interval_ticks", 32'(want.interval_ticks),
                                32'(result_ch.interval_ticks));
                    check_field("speed_rpm", 32'(want.speed_rpm), 32'(result_ch.speed_rpm));
                    check_field("pulse_total", want.pulse_total, result_ch.pulse_total);
                    check_field("glitch_total", want.glitch_total, result_ch.glitch_total);
                    results_checked++;
                end
            end
            if (hold_served != hold_request) begin
                hold_served    = hold_request;
                long_hold_left = 400;
            end
            if (mode_left == 0) begin
                stall_mode = $urandom_range(0, 2);
                mode_left  = $urandom_range(40, 300);
            end
            else begin
                mode_left--;
            end
            if (long_hold_left > 0) begin
                long_hold_left--;
                result_ch.ready <= 1'b0;
            end
            else begin
                case (stall_mode)
                    0:       result_ch.ready <= 1'b1;
                    1:       result_ch.ready <= 1'($urandom_range(0, 1));
                    default: result_ch.ready <= ($urandom_range(0, 5) == 0);
                endcase
            end
        end
    end

    // ---------------- stimulus ----------------
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_MIN_INTERVAL)
            cur_min_interval = data[MIN_W-1:0];
        else
            cur_scale = data;
    endtask

    task automatic wait_drained();
        @(negedge clk);
        while (stamp_q.size() != 0 || sensor_ch.valid || speed_expect_q.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic queue_stamp(input logic [TIMER_IN_W-1:0] stamp);
        if (wrap_interval(stamp, gen_last) >= {1'b0, cur_min_interval})
            gen_last = stamp;
        stamp_q.push_back(stamp);
    endtask

    task automatic queue_random_stamp();
        int unsigned pick;
        int          d;
        pick = $urandom_range(0, 99);
        if (pick < 40) begin
            // right around the glitch threshold
            d = int'(cur_min_interval) + $urandom_range(0, 6) - 3;
            if (d < 1) d = 1;
            if (d > 65536) d = 65536;
        end
        else if (pick < 60) begin
            d = $urandom_range(1, 65536);
        end
        else if (pick < 75) begin
            d = (cur_min_interval > 1) ? $urandom_range(1, cur_min_interval - 1) : 1;
        end
        else begin
            d = $urandom_range(65530, 65536);
        end
        if (pick >= 88)
            queue_stamp(16'($urandom));
        else
            queue_stamp(gen_last + 16'(d));
    endtask

    initial begin
        logic [MIN_W-1:0]   new_min;
        logic [SCALE_W-1:0] new_scale;
        int                 phase;

        rst_n                 = 1'b0;
        cfg_we                = 1'b0;
        cfg_index             = '0;
        cfg_data              = '0;
        sensor_ch.valid       = 1'b0;
        sensor_ch.timer_count = '0;
        result_ch.ready       = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // defaults: first edge from a zero stamp, glitch, full wrap, exact minimum
        queue_stamp(16'd0);
        queue_stamp(16'd100);
        queue_stamp(16'd0);
        queue_stamp(16'd5666);
        queue_stamp(16'd11331);
        queue_stamp(16'hFFFF);
        queue_stamp(16'd5665);
        wait_drained();
        settings_done++;

        // shortest interval with the largest numerator
        write_reg(REG_MIN_INTERVAL, 32'd1);
        write_reg(REG_SPEED_SCALE, 32'hFFFF_FFFF);
        @(negedge clk);
        queue_stamp(16'd5666);
        queue_stamp(16'd5666);
        queue_stamp(16'd5668);
        wait_drained();
        settings_done++;

        // largest minimum, unit numerator
        write_reg(REG_MIN_INTERVAL, 32'h0000_FFFF);
        write_reg(REG_SPEED_SCALE, 32'd1);
        @(negedge clk);
        queue_stamp(16'd5666);
        queue_stamp(16'd5667);
        queue_stamp(16'd5667);
        queue_stamp(16'd5668);
        wait_drained();
        settings_done++;

        // zero minimum: nothing is a glitch
        write_reg(REG_MIN_INTERVAL, 32'hABCD_0000);
        write_reg(REG_SPEED_SCALE, 32'h0001_0000);
        @(negedge clk);
        queue_stamp(16'd5668);
        queue_stamp(16'd5668);
        queue_stamp(16'd0);
        queue_stamp(16'hFFFF);
        queue_stamp(16'h5555);
        queue_stamp(16'hAAAA);
        wait_drained();
        settings_done++;

        for (phase = 0; phase < 8; phase++) begin
            case (phase)
                0: begin
                    new_min   = MIN_INTERVAL_RST;
                    new_scale = SPEED_SCALE_RST;
                end
                1: begin
                    new_min   = 16'd1;
                    new_scale = 32'hFFFF_FFFF;
                end
                2: begin
                    new_min   = 16'hFFFF;
                    new_scale = 32'd1;
                end
                4: begin
                    new_min   = 16'($urandom_range(1, 2000));
                    new_scale = $urandom_range(1000, 200000);
                end
                5: begin
                    new_min   = 16'd30000;
                    new_scale = 32'h8000_0000;
                end
                default: begin
                    new_min   = 16'($urandom_range(1, 65535));
                    new_scale = $urandom;
                    if (new_scale == '0) new_scale = 32'd1;
                end
            endcase
            // upper data bits are don't-care for the 16-bit register
            write_reg(REG_MIN_INTERVAL, {16'($urandom), new_min});
            write_reg(REG_SPEED_SCALE, new_scale);
            @(negedge clk);
            if (phase == 3)
                hold_request <= hold_request + 1;
            repeat (210) queue_random_stamp();
            wait_drained();
            settings_done++;
        end

        repeat (40) @(negedge clk);
        $display("Checked %0d results: %0d accepted edges, %0d glitches, %0d register settings",
                 results_checked, pulses_seen, glitches_seen, settings_done);
        $display("Settings spanned minimum 0..65535 and numerator 1..2^32-1, with stalls");
        if (fail_count == 0)
            $display("pulse_period_to_rpm_core verification clean");
        else
            $display("pulse_period_to_rpm_core verification failed");
        $finish;
    end

endmodule
